>>> rtl/pft_pkg.sv
// pft_pkg: shared types, widths, register codes and arithmetic helpers
// for the pose frame transform block
// depends on nothing; every rtl file uses it
package pft_pkg;

  // field widths
  localparam int POS_W  = 24;
  localparam int ROT_W  = 16;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 24;

  // internal widths
  localparam int MAT_W  = 26;  // rotation matrix entry, Q20
  localparam int M_W    = 32;  // composite matrix entry, Q20
  localparam int SQ_W   = 62;  // square root operand
  localparam int RT_W   = SQ_W / 2;
  localparam int NUM_W  = 46;  // divider numerator magnitude
  localparam int QT_W   = 16;  // divider quotient bits

  localparam logic [RT_W-1:0] FB_EPS = 31'd109951163;
  localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;

  // register reset values
  localparam logic signed [POS_W-1:0] CAM_POS_X_RST = 24'sd21782;
  localparam logic signed [POS_W-1:0] CAM_POS_Y_RST = -24'sd988;
  localparam logic signed [POS_W-1:0] CAM_POS_Z_RST = 24'sd8359;
  localparam logic signed [ROT_W-1:0] CAM_ROT_X_RST = -16'sd11225;
  localparam logic signed [ROT_W-1:0] CAM_ROT_Y_RST = 16'sd11817;
  localparam logic signed [ROT_W-1:0] CAM_ROT_Z_RST = -16'sd1316;
  localparam logic signed [ROT_W-1:0] CAM_ROT_W_RST = 16'sd1036;

  // register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_CAM_POS_X = 3'd0,
    CFG_CAM_POS_Y = 3'd1,
    CFG_CAM_POS_Z = 3'd2,
    CFG_CAM_ROT_X = 3'd3,
    CFG_CAM_ROT_Y = 3'd4,
    CFG_CAM_ROT_Z = 3'd5,
    CFG_CAM_ROT_W = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] obj_pos_x;
    logic signed [POS_W-1:0] obj_pos_y;
    logic signed [POS_W-1:0] obj_pos_z;
    logic signed [ROT_W-1:0] obj_rot_x;
    logic signed [ROT_W-1:0] obj_rot_y;
    logic signed [ROT_W-1:0] obj_rot_z;
    logic signed [ROT_W-1:0] obj_rot_w;
  } in_beat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] base_pos_x;
    logic signed [POS_W-1:0] base_pos_y;
    logic signed [POS_W-1:0] base_pos_z;
    logic signed [ROT_W-1:0] base_rot_x;
    logic signed [ROT_W-1:0] base_rot_y;
    logic signed [ROT_W-1:0] base_rot_z;
    logic signed [ROT_W-1:0] base_rot_w;
  } out_beat_t;

  // pairwise quaternion products, Q28
  typedef struct packed {
    logic signed [31:0] aa, bb, cc, dd, bc, ad, bd, ac, cd, ab;
  } qprod_t;

  typedef logic [2:0][2:0][MAT_W-1:0] mat_t;

  function automatic qprod_t quat_prods(input logic signed [ROT_W-1:0] x,
                                        input logic signed [ROT_W-1:0] y,
                                        input logic signed [ROT_W-1:0] z,
                                        input logic signed [ROT_W-1:0] w);
    qprod_t p;
    p.aa = 32'(w) * 32'(w);
    p.bb = 32'(x) * 32'(x);
    p.cc = 32'(y) * 32'(y);
    p.dd = 32'(z) * 32'(z);
    p.bc = 32'(x) * 32'(y);
    p.ad = 32'(w) * 32'(z);
    p.bd = 32'(x) * 32'(z);
    p.ac = 32'(w) * 32'(y);
    p.cd = 32'(y) * 32'(z);
    p.ab = 32'(w) * 32'(x);
    return p;
  endfunction

  // Q28 to Q20, round half up
  function automatic logic [MAT_W-1:0] rnd_term(input logic signed [34:0] t);
    logic signed [34:0] r;
    r = (t + 35'sd128) >>> 8;
    return r[MAT_W-1:0];
  endfunction

  function automatic mat_t quat_mat(input qprod_t p);
    mat_t m;
    m[0][0] = rnd_term(((35'(p.aa) + 35'(p.bb)) <<< 1) - ONE_Q28);
    m[0][1] = rnd_term((35'(p.bc) - 35'(p.ad)) <<< 1);
    m[0][2] = rnd_term((35'(p.bd) + 35'(p.ac)) <<< 1);
    m[1][0] = rnd_term((35'(p.bc) + 35'(p.ad)) <<< 1);
    m[1][1] = rnd_term(((35'(p.aa) + 35'(p.cc)) <<< 1) - ONE_Q28);
    m[1][2] = rnd_term((35'(p.cd) - 35'(p.ab)) <<< 1);
    m[2][0] = rnd_term((35'(p.bd) - 35'(p.ac)) <<< 1);
    m[2][1] = rnd_term((35'(p.cd) + 35'(p.ab)) <<< 1);
    m[2][2] = rnd_term(((35'(p.aa) + 35'(p.dd)) <<< 1) - ONE_Q28);
    return m;
  endfunction

  // Q36 sum to Q16 position, rounded and saturated
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [52:0] a);
    logic signed [52:0] r;
    r = (a + 53'sd524288) >>> 20;
    if (r > 53'sd8388607) return 24'sh7FFFFF;
    if (r < -53'sd8388608) return 24'sh800000;
    return r[POS_W-1:0];
  endfunction

  // apply sign to a quotient magnitude and saturate to 16 bits
  function automatic logic signed [ROT_W-1:0] sat_quot(input logic [QT_W-1:0] q,
                                                       input logic ovf,
                                                       input logic neg);
    if (!neg) return (ovf || q > 16'd32767) ? 16'sh7FFF : q;
    return (ovf || q > 16'd32768) ? 16'sh8000 : 16'(~q + 16'd1);
  endfunction

endpackage

>>> rtl/pft_sqrt_pipe.sv
// pft_sqrt_pipe: pipelined floor square root, one root bit per stage,
// with a sideband word carried alongside; depends on pft_pkg for defaults
module pft_sqrt_pipe #(
  parameter int W  = pft_pkg::SQ_W,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_in,
  input  logic [W-1:0]    x_in,
  input  logic [SW-1:0]   side_in,
  output logic            v_out,
  output logic [W/2-1:0]  root_out,
  output logic [SW-1:0]   side_out
);

  localparam int N = W / 2;

  logic [W-1:0]   x_r    [N+1];
  logic [N+1:0]   rem_r  [N+1];
  logic [N-1:0]   root_r [N+1];
  logic [SW-1:0]  side_r [N+1];
  logic           v_r    [N+1];
  logic [W-1:0]   x_nxt    [N];
  logic [N+1:0]   rem_nxt  [N];
  logic [N-1:0]   root_nxt [N];

  // one digit step per stage
  always_comb begin
    logic [N+3:0] cand, trial, diff;
    for (int i = 0; i < N; i++) begin
      cand  = {rem_r[i], x_r[i][W-1 -: 2]};
      trial = {2'b00, root_r[i], 2'b01};
      diff  = cand - trial;
      x_nxt[i] = x_r[i] << 2;
      if (cand >= trial) begin
        rem_nxt[i]  = diff[N+1:0];
        root_nxt[i] = {root_r[i][N-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = cand[N+1:0];
        root_nxt[i] = {root_r[i][N-2:0], 1'b0};
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_in;
      for (int i = 0; i < N; i++) v_r[i+1] <= v_r[i];
    end
  end

  // data chain
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x_in;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= side_in;
      for (int i = 0; i < N; i++) begin
        x_r[i+1]    <= x_nxt[i];
        rem_r[i+1]  <= rem_nxt[i];
        root_r[i+1] <= root_nxt[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign v_out    = v_r[N];
  assign root_out = root_r[N];
  assign side_out = side_r[N];

endmodule

>>> rtl/pft_div_pipe.sv
// pft_div_pipe: pipelined restoring divider, one quotient bit per stage,
// flags quotients that do not fit; depends on pft_pkg for defaults
module pft_div_pipe #(
  parameter int NW = pft_pkg::NUM_W,
  parameter int DW = pft_pkg::RT_W,
  parameter int QW = pft_pkg::QT_W,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           v_in,
  input  logic [NW-1:0]  num_in,
  input  logic [DW-1:0]  den_in,
  input  logic [SW-1:0]  side_in,
  output logic           v_out,
  output logic [QW-1:0]  q_out,
  output logic           ovf_out,
  output logic [SW-1:0]  side_out
);

  logic [DW-1:0]  rem_r  [QW+1];
  logic [QW-1:0]  lo_r   [QW+1];
  logic [QW-1:0]  q_r    [QW+1];
  logic [DW-1:0]  den_r  [QW+1];
  logic           ovf_r  [QW+1];
  logic [SW-1:0]  side_r [QW+1];
  logic           v_r    [QW+1];
  logic [DW-1:0]  rem_nxt [QW];
  logic [QW-1:0]  q_nxt   [QW];

  // trial subtract per stage
  always_comb begin
    logic [DW:0] cand, diff;
    for (int i = 0; i < QW; i++) begin
      cand = {rem_r[i], lo_r[i][QW-1]};
      diff = cand - {1'b0, den_r[i]};
      if (cand >= {1'b0, den_r[i]}) begin
        rem_nxt[i] = diff[DW-1:0];
        q_nxt[i]   = {q_r[i][QW-2:0], 1'b1};
      end else begin
        rem_nxt[i] = cand[DW-1:0];
        q_nxt[i]   = {q_r[i][QW-2:0], 1'b0};
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QW; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_in;
      for (int i = 0; i < QW; i++) v_r[i+1] <= v_r[i];
    end
  end

  // data chain, entry splits off the high part and checks for overflow
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DW'(num_in >> QW);
      lo_r[0]   <= num_in[QW-1:0];
      q_r[0]    <= '0;
      den_r[0]  <= den_in;
      ovf_r[0]  <= (num_in >> QW) >= NW'(den_in);
      side_r[0] <= side_in;
      for (int i = 0; i < QW; i++) begin
        rem_r[i+1]  <= rem_nxt[i];
        lo_r[i+1]   <= lo_r[i] << 1;
        q_r[i+1]    <= q_nxt[i];
        den_r[i+1]  <= den_r[i];
        ovf_r[i+1]  <= ovf_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign v_out    = v_r[QW];
  assign q_out    = q_r[QW];
  assign ovf_out  = ovf_r[QW];
  assign side_out = side_r[QW];

endmodule

>>> rtl/pose_frame_transform.sv
// pose_frame_transform: re-expresses an object pose from camera frame into
// base frame; depends on pft_pkg, pft_sqrt_pipe and pft_div_pipe
//
//  port group | dir | carries
//  in_*       | in  | object pose beat, valid/stall
//  out_*      | out | base frame pose beat, valid/stall
//  cfg_*      | in  | camera pose register writes
//
// one pose per cycle while the output is not stalled; 8 arithmetic stages, 32 of the
// square root pipe (one root bit per stage), 1 select, 17 of the divider
// pipe (one quotient bit per stage) and the output register.
// synchronous active-low reset clears valid bits and loads camera defaults.
// a stalled output beat freezes the whole pipe; no beat is dropped.
module pose_frame_transform (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  pft_pkg::in_beat_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output pft_pkg::out_beat_t         out_data,
  input  logic                       cfg_we,
  input  logic [pft_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [pft_pkg::CFG_DW-1:0] cfg_wdata
);
  import pft_pkg::*;

  localparam int D_W  = 33;
  localparam int SA_W = 3 * POS_W + 3 * D_W;
  localparam int SB_W = 3 * 32 + 1;
  localparam int S0_W = 3 * POS_W + RT_W + 2;

  logic en;

  // camera registers
  logic signed [POS_W-1:0] cam_pos_r [3];
  logic signed [ROT_W-1:0] cam_rot_r [4];
  qprod_t cam_prod_r;
  mat_t   rc_r;

  // pipeline stages
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v10_r;
  logic [2:0][POS_W-1:0] pos1_r, pos2_r;
  qprod_t op1_r;
  mat_t   ro2_r;
  logic signed [49:0] pp3_r [3][3];
  logic signed [51:0] mp3_r [3][3][3];
  logic [2:0][POS_W-1:0] bpos_nxt, bpos4_r, bpos5_r, bpos6_r, bpos7_r, bpos8_r, bpos10_r;
  logic signed [M_W-1:0] m_nxt [3][3];
  logic signed [M_W-1:0] m4_r  [3][3];
  logic [31:0] t_nxt, t5_r, t6_r, t7_r, t8_r;
  logic [2:0][D_W-1:0] d_nxt, d5_r, d6_r, d7_r, d8_r;
  logic signed [63:0] pr_nxt [3];
  logic signed [63:0] pr5_r  [3];
  logic signed [63:0] pr6_r  [3];
  logic [5:0] sh_nxt, sh6_r;
  logic [2:0][31:0] prs_nxt, pr7_r, pr8_r;
  logic sz7_r, sz8_r;
  logic [SQ_W-1:0] sq_nxt [3];
  logic [SQ_W-1:0] sq8_r  [3];

  // square root outputs
  logic va, vb;
  logic [RT_W-1:0] root_a, root_b;
  logic [SA_W-1:0] side_a;
  logic [SB_W-1:0] side_b;
  logic [2:0][POS_W-1:0] bpos_s;
  logic [2:0][D_W-1:0] d_s;
  logic [2:0][31:0] pr_s;
  logic sz_s;

  // select stage
  logic [NUM_W-1:0] num_nxt [3];
  logic [NUM_W-1:0] num10_r [3];
  logic [2:0] neg_nxt, neg10_r;
  logic [RT_W-1:0] den_nxt, den10_r, qw10_r;
  logic spec_nxt, spec10_r;

  // divider outputs
  logic dv0, dv1, dv2;
  logic [QT_W-1:0] q0, q1, q2;
  logic ovf0, ovf1, ovf2;
  logic [S0_W-1:0] side0;
  logic neg1_o, neg2_o;
  logic [2:0][POS_W-1:0] bpos_o;
  logic [RT_W-1:0] qw_o;
  logic spec_o, neg0_o;

  out_beat_t out_nxt, out_data_r;
  logic      out_valid_r;

  // whole pipe advances unless the output beat is held
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_pos_r[0] <= CAM_POS_X_RST;
      cam_pos_r[1] <= CAM_POS_Y_RST;
      cam_pos_r[2] <= CAM_POS_Z_RST;
      cam_rot_r[0] <= CAM_ROT_X_RST;
      cam_rot_r[1] <= CAM_ROT_Y_RST;
      cam_rot_r[2] <= CAM_ROT_Z_RST;
      cam_rot_r[3] <= CAM_ROT_W_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CAM_POS_X: cam_pos_r[0] <= cfg_wdata;
        CFG_CAM_POS_Y: cam_pos_r[1] <= cfg_wdata;
        CFG_CAM_POS_Z: cam_pos_r[2] <= cfg_wdata;
        CFG_CAM_ROT_X: cam_rot_r[0] <= cfg_wdata[ROT_W-1:0];
        CFG_CAM_ROT_Y: cam_rot_r[1] <= cfg_wdata[ROT_W-1:0];
        CFG_CAM_ROT_Z: cam_rot_r[2] <= cfg_wdata[ROT_W-1:0];
        CFG_CAM_ROT_W: cam_rot_r[3] <= cfg_wdata[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  // camera rotation matrix, recomputed every cycle
  always_ff @(posedge clk) begin
    cam_prod_r <= quat_prods(cam_rot_r[0], cam_rot_r[1], cam_rot_r[2], cam_rot_r[3]);
    rc_r       <= quat_mat(cam_prod_r);
  end

  // position sums and composite matrix
  always_comb begin
    logic signed [52:0] acc;
    logic signed [53:0] s, mt;
    for (int i = 0; i < 3; i++) begin
      acc = (53'(cam_pos_r[i]) <<< 20) + 53'(pp3_r[i][0]) + 53'(pp3_r[i][1])
            + 53'(pp3_r[i][2]);
      bpos_nxt[i] = sat_pos(acc);
      for (int j = 0; j < 3; j++) begin
        s  = 54'(mp3_r[i][j][0]) + 54'(mp3_r[i][j][1]) + 54'(mp3_r[i][j][2]);
        mt = (s + 54'sd524288) >>> 20;
        m_nxt[i][j] = mt[M_W-1:0];
      end
    end
  end

  // trace, differences, fallback products
  always_comb begin
    logic signed [33:0] tr;
    tr = 34'(m4_r[0][0]) + 34'(m4_r[1][1]) + 34'(m4_r[2][2]) + 34'sd1048576;
    t_nxt = tr[33] ? 32'd0 : tr[31:0];
    d_nxt[0] = 33'(m4_r[2][1]) - 33'(m4_r[1][2]);
    d_nxt[1] = 33'(m4_r[0][2]) - 33'(m4_r[2][0]);
    d_nxt[2] = 33'(m4_r[1][0]) - 33'(m4_r[0][1]);
    pr_nxt[0] = 64'(m4_r[0][1]) * 64'(m4_r[0][2]);
    pr_nxt[1] = 64'(m4_r[0][1]) * 64'(m4_r[1][2]);
    pr_nxt[2] = 64'(m4_r[0][2]) * 64'(m4_r[1][2]);
  end

  // fallback shift from the leading one of the largest magnitude
  always_comb begin
    logic [63:0] orm, mg;
    logic [6:0]  bl;
    orm = '0;
    for (int k = 0; k < 3; k++) begin
      mg  = pr5_r[k][63] ? 64'(-pr5_r[k]) : 64'(pr5_r[k]);
      orm = orm | mg;
    end
    bl = '0;
    for (int b = 0; b < 64; b++) begin
      if (orm[b]) bl = 7'(b + 1);
    end
    sh_nxt = (bl > 7'd30) ? 6'(bl - 7'd30) : 6'd0;
  end

  // rounded fallback shift
  always_comb begin
    logic signed [63:0] half, x;
    half = (sh6_r == 6'd0) ? 64'sd0 : (64'sd1 <<< (sh6_r - 6'd1));
    for (int k = 0; k < 3; k++) begin
      x = (pr6_r[k] + half) >>> sh6_r;
      prs_nxt[k] = x[31:0];
    end
  end

  // fallback squares
  always_comb begin
    logic signed [63:0] p;
    for (int k = 0; k < 3; k++) begin
      p = 64'($signed(pr7_r[k])) * 64'($signed(pr7_r[k]));
      sq_nxt[k] = p[SQ_W-1:0];
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
      v10_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r;
      v10_r <= va & vb;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      pos1_r <= {in_data.obj_pos_z, in_data.obj_pos_y, in_data.obj_pos_x};
      op1_r  <= quat_prods(in_data.obj_rot_x, in_data.obj_rot_y,
                           in_data.obj_rot_z, in_data.obj_rot_w);
      pos2_r <= pos1_r;
      ro2_r  <= quat_mat(op1_r);
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pp3_r[i][k] <= 50'($signed(rc_r[i][k])) * 50'($signed(pos2_r[k]));
          for (int j = 0; j < 3; j++)
            mp3_r[i][j][k] <= 52'($signed(rc_r[i][k])) * 52'($signed(ro2_r[k][j]));
        end
      end
      bpos4_r <= bpos_nxt;
      m4_r    <= m_nxt;
      bpos5_r <= bpos4_r;
      t5_r    <= t_nxt;
      d5_r    <= d_nxt;
      pr5_r   <= pr_nxt;
      bpos6_r <= bpos5_r;
      t6_r    <= t5_r;
      d6_r    <= d5_r;
      pr6_r   <= pr5_r;
      sh6_r   <= sh_nxt;
      bpos7_r <= bpos6_r;
      t7_r    <= t6_r;
      d7_r    <= d6_r;
      pr7_r   <= prs_nxt;
      sz7_r   <= (sh6_r == 6'd0);
      bpos8_r <= bpos7_r;
      t8_r    <= t7_r;
      d8_r    <= d7_r;
      pr8_r   <= pr7_r;
      sz8_r   <= sz7_r;
      sq8_r   <= sq_nxt;
    end
  end

  // scalar part root
  pft_sqrt_pipe #(.W(SQ_W), .SW(SA_W)) u_sqrt_w (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (v8_r),
    .x_in     (SQ_W'(t8_r) << 6),
    .side_in  ({bpos8_r, d8_r}),
    .v_out    (va),
    .root_out (root_a),
    .side_out (side_a)
  );

  // fallback norm root
  pft_sqrt_pipe #(.W(SQ_W), .SW(SB_W)) u_sqrt_fb (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (v8_r),
    .x_in     (sq8_r[0] + sq8_r[1] + sq8_r[2]),
    .side_in  ({pr8_r, sz8_r}),
    .v_out    (vb),
    .root_out (root_b),
    .side_out (side_b)
  );

  assign bpos_s = side_a[SA_W-1 -: 3*POS_W];
  assign d_s    = side_a[3*D_W-1:0];
  assign pr_s   = side_b[SB_W-1:1];
  assign sz_s   = side_b[0];

  // choose trace or fallback numerators and divisor
  always_comb begin
    logic main;
    logic signed [38:0] nm;
    logic signed [NUM_W-1:0] nf;
    logic [NUM_W-1:0] mg;
    main     = root_a > RT_W'(1);
    den_nxt  = main ? root_a : root_b;
    spec_nxt = !main && sz_s && (root_b < FB_EPS);
    for (int k = 0; k < 3; k++) begin
      nm = 39'($signed(d_s[k])) <<< 6;
      nf = NUM_W'($signed(pr_s[k])) <<< 14;
      if (main) begin
        neg_nxt[k] = d_s[k][D_W-1];
        mg = neg_nxt[k] ? NUM_W'(-nm) : NUM_W'(nm);
      end else begin
        neg_nxt[k] = pr_s[k][31];
        mg = neg_nxt[k] ? NUM_W'(-nf) : NUM_W'(nf);
      end
      num_nxt[k] = mg + NUM_W'(den_nxt >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bpos10_r <= bpos_s;
      qw10_r   <= root_a;
      spec10_r <= spec_nxt;
      num10_r  <= num_nxt;
      neg10_r  <= neg_nxt;
      den10_r  <= den_nxt;
    end
  end

  // three vector part dividers
  pft_div_pipe #(.NW(NUM_W), .DW(RT_W), .QW(QT_W), .SW(S0_W)) u_div_x (
    .clk (clk), .rst_n (rst_n), .en (en), .v_in (v10_r),
    .num_in (num10_r[0]), .den_in (den10_r),
    .side_in ({bpos10_r, qw10_r, spec10_r, neg10_r[0]}),
    .v_out (dv0), .q_out (q0), .ovf_out (ovf0), .side_out (side0)
  );

  pft_div_pipe #(.NW(NUM_W), .DW(RT_W), .QW(QT_W), .SW(1)) u_div_y (
    .clk (clk), .rst_n (rst_n), .en (en), .v_in (v10_r),
    .num_in (num10_r[1]), .den_in (den10_r), .side_in (neg10_r[1]),
    .v_out (dv1), .q_out (q1), .ovf_out (ovf1), .side_out (neg1_o)
  );

  pft_div_pipe #(.NW(NUM_W), .DW(RT_W), .QW(QT_W), .SW(1)) u_div_z (
    .clk (clk), .rst_n (rst_n), .en (en), .v_in (v10_r),
    .num_in (num10_r[2]), .den_in (den10_r), .side_in (neg10_r[2]),
    .v_out (dv2), .q_out (q2), .ovf_out (ovf2), .side_out (neg2_o)
  );

  assign {bpos_o, qw_o, spec_o, neg0_o} = side0;

  // output beat assembly
  always_comb begin
    out_nxt.base_pos_x = bpos_o[0];
    out_nxt.base_pos_y = bpos_o[1];
    out_nxt.base_pos_z = bpos_o[2];
    if (spec_o) begin
      out_nxt.base_rot_x = '0;
      out_nxt.base_rot_y = 16'sd16384;
      out_nxt.base_rot_z = '0;
      out_nxt.base_rot_w = '0;
    end else begin
      out_nxt.base_rot_x = sat_quot(q0, ovf0, neg0_o);
      out_nxt.base_rot_y = sat_quot(q1, ovf1, neg1_o);
      out_nxt.base_rot_z = sat_quot(q2, ovf2, neg2_o);
      out_nxt.base_rot_w = (qw_o > RT_W'(32767)) ? 16'sh7FFF : qw_o[ROT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv0 & dv1 & dv2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // reset empties the output register
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

  // parallel root and divider lanes stay in step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (va == vb) && (dv0 == dv1) && (dv1 == dv2))
    else $error("pipeline lanes out of step");

  // scalar part is never negative
  a_w_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !out_data_r.base_rot_w[ROT_W-1])
    else $error("negative scalar part");

endmodule
